>>> sv/mvpi_pkg.sv
`default_nettype none

package mvpi_pkg;

    localparam int SPEED_WIDTH_DEF = 16;
    localparam int ACC_FRAC_DEF    = 8;

    localparam int ACC_WIDTH       = 40;
    localparam int GAIN_WIDTH      = 16;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int LIMIT_WIDTH     = 15;
    localparam int DRIVE_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int DIV_WIDTH       = 2;
    localparam int DELAY_WIDTH     = 3;
    localparam int OUT_TDATA_WIDTH = 40;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'd3500;
    localparam logic [DIV_WIDTH-1:0]   DIV_RESET   = 2'd1;
    localparam logic [DIV_WIDTH-1:0]   DIV_TOP     = 2'd2;
    localparam logic [DELAY_WIDTH-1:0] DELAY_END   = 3'd5;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_INTEG_GAIN  = 2'd1,
        REG_DRIVE_LIMIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic updated;
        logic busy;
    } tick_ctrl_t;

endpackage

`default_nettype wire

>>> sv/motor_velocity_incremental_pi.sv
// channel   dir  transaction contents (tdata, lowest bit first)
// s_axis    in   encoder_speed, target_speed, delay_request
// m_axis    out  pwm_magnitude, motor_drive, loop_updated, delay_busy
// cfg       in   prop_gain, integ_gain, drive_limit by index, write only
//
// one transaction per cycle in and out unless m_tready holds a result; a tick taken passes
// through the five register stages: input, multiply, product sum, accumulator, result
// reset is synchronous on aresetn low: gains 0, drive limit 3500, pipeline empty
// a result held by m_tready low freezes every stage and drops s_tready in the same cycle
`default_nettype none

module motor_velocity_incremental_pi #(
    parameter int SPEED_WIDTH   = mvpi_pkg::SPEED_WIDTH_DEF,
    parameter int ACC_FRAC_BITS = mvpi_pkg::ACC_FRAC_DEF
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,

    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    // encoder_speed, target_speed, delay_request, zero pad
    input  wire logic [((2*SPEED_WIDTH+8)/8)*8-1:0]         s_tdata,

    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    // pwm_magnitude[14:0], motor_drive[30:15], loop_updated[31], delay_busy[32], zero pad
    output logic [mvpi_pkg::OUT_TDATA_WIDTH-1:0]            m_tdata,

    input  wire logic                                       cfg_we,
    input  wire logic [mvpi_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  wire logic [mvpi_pkg::CFG_DATA_WIDTH-1:0]        cfg_data
);

    logic [mvpi_pkg::GAIN_WIDTH-1:0]  prop_gain_reg;
    logic [mvpi_pkg::GAIN_WIDTH-1:0]  integ_gain_reg;
    logic [mvpi_pkg::LIMIT_WIDTH-1:0] drive_limit_reg;

    logic                             adv;
    mvpi_pkg::tick_ctrl_t             ctrl1, ctrl3;
    logic signed [SPEED_WIDTH+18:0]   prop_term;
    logic signed [SPEED_WIDTH+17:0]   integ_term;
    logic signed [mvpi_pkg::ACC_WIDTH-1:0] acc;

    logic                             out_valid;
    logic [mvpi_pkg::LIMIT_WIDTH-1:0] pwm_magnitude;
    logic signed [mvpi_pkg::DRIVE_WIDTH-1:0] motor_drive;
    logic                             loop_updated, delay_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            drive_limit_reg <= mvpi_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            case (mvpi_pkg::cfg_index_t'(cfg_index))
                mvpi_pkg::REG_PROP_GAIN: begin
                    prop_gain_reg <= cfg_data;
                end
                mvpi_pkg::REG_INTEG_GAIN: begin
                    integ_gain_reg <= cfg_data;
                end
                mvpi_pkg::REG_DRIVE_LIMIT: begin
                    drive_limit_reg <= cfg_data[mvpi_pkg::LIMIT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // whole pipeline moves when the result slot is free or being emptied
    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;

    mvpi_front #(
        .SPEED_WIDTH(SPEED_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (s_tvalid),
        .encoder_speed (s_tdata[SPEED_WIDTH-1:0]),
        .target_speed  (s_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH]),
        .delay_request (s_tdata[2*SPEED_WIDTH]),
        .prop_gain     (prop_gain_reg),
        .integ_gain    (integ_gain_reg),
        .ctrl_out      (ctrl1),
        .prop_term     (prop_term),
        .integ_term    (integ_term)
    );

    mvpi_accum #(
        .SPEED_WIDTH   (SPEED_WIDTH),
        .ACC_FRAC_BITS (ACC_FRAC_BITS)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .ctrl_in    (ctrl1),
        .prop_term  (prop_term),
        .integ_term (integ_term),
        .ctrl_out   (ctrl3),
        .acc        (acc)
    );

    mvpi_drive #(
        .ACC_FRAC_BITS (ACC_FRAC_BITS)
    ) u_drive (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .ctrl_in       (ctrl3),
        .acc           (acc),
        .drive_limit   (drive_limit_reg),
        .out_valid     (out_valid),
        .pwm_magnitude (pwm_magnitude),
        .motor_drive   (motor_drive),
        .loop_updated  (loop_updated),
        .delay_busy    (delay_busy)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'd0, delay_busy, loop_updated, motor_drive, pwm_magnitude};

endmodule

`default_nettype wire

>>> sv/mvpi_front.sv
`default_nettype none

module mvpi_front #(
    parameter int SPEED_WIDTH = mvpi_pkg::SPEED_WIDTH_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   adv,
    input  wire logic                                   in_valid,
    input  wire logic signed [SPEED_WIDTH-1:0]          encoder_speed,
    input  wire logic signed [SPEED_WIDTH-1:0]          target_speed,
    input  wire logic                                   delay_request,
    input  wire logic [mvpi_pkg::GAIN_WIDTH-1:0]        prop_gain,
    input  wire logic [mvpi_pkg::GAIN_WIDTH-1:0]        integ_gain,
    output mvpi_pkg::tick_ctrl_t                        ctrl_out,
    output logic signed [SPEED_WIDTH+18:0]              prop_term,
    output logic signed [SPEED_WIDTH+17:0]              integ_term
);

    localparam int ERR_W  = SPEED_WIDTH + 1;
    localparam int DIFF_W = SPEED_WIDTH + 2;
    localparam int PROP_W = SPEED_WIDTH + 19;
    localparam int INTEG_W = SPEED_WIDTH + 18;

    // input register
    logic                          in_valid_reg;
    logic signed [SPEED_WIDTH-1:0] enc_reg;
    logic signed [SPEED_WIDTH-1:0] tgt_reg;
    logic                          req_reg;

    // tick state
    logic [mvpi_pkg::DIV_WIDTH-1:0]   div_reg, div_next;
    logic [mvpi_pkg::DELAY_WIDTH-1:0] delay_cnt_reg, delay_cnt_next;
    logic                             delay_act_reg, delay_act_next;
    logic signed [ERR_W-1:0]          prev_err_reg, prev_err_next;

    logic                             upd;
    logic signed [ERR_W-1:0]          err;
    logic signed [DIFF_W-1:0]         diff;
    logic signed [mvpi_pkg::GAIN_WIDTH:0] kp_s, ki_s;

    mvpi_pkg::tick_ctrl_t             ctrl_reg;
    logic signed [PROP_W-1:0]         prop_reg;
    logic signed [INTEG_W-1:0]        integ_reg;

    always_comb begin
        delay_act_next = delay_act_reg | req_reg;
        delay_cnt_next = delay_cnt_reg;
        if (delay_act_next) begin
            delay_cnt_next = delay_cnt_reg + 3'd1;
            if (delay_cnt_next == mvpi_pkg::DELAY_END) begin
                delay_cnt_next = '0;
                delay_act_next = 1'b0;
            end
        end

        upd      = div_reg > mvpi_pkg::DIV_TOP;
        div_next = (upd ? mvpi_pkg::DIV_RESET : div_reg) + 2'd1;

        err  = ERR_W'(enc_reg) - ERR_W'(tgt_reg);
        diff = DIFF_W'(err) - DIFF_W'(prev_err_reg);
        prev_err_next = upd ? err : prev_err_reg;

        kp_s = $signed({1'b0, prop_gain});
        ki_s = $signed({1'b0, integ_gain});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            ctrl_reg      <= '0;
            div_reg       <= mvpi_pkg::DIV_RESET;
            delay_cnt_reg <= '0;
            delay_act_reg <= 1'b0;
            prev_err_reg  <= '0;
        end else if (adv) begin
            in_valid_reg     <= in_valid;
            ctrl_reg.valid   <= in_valid_reg;
            ctrl_reg.updated <= upd;
            ctrl_reg.busy    <= delay_act_next;
            if (in_valid_reg) begin
                div_reg       <= div_next;
                delay_cnt_reg <= delay_cnt_next;
                delay_act_reg <= delay_act_next;
                prev_err_reg  <= prev_err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            enc_reg <= encoder_speed;
            tgt_reg <= target_speed;
            req_reg <= delay_request;
        end
        if (adv) begin
            prop_reg  <= PROP_W'(kp_s) * PROP_W'(diff);
            integ_reg <= INTEG_W'(ki_s) * INTEG_W'(err);
        end
    end

    assign ctrl_out   = ctrl_reg;
    assign prop_term  = prop_reg;
    assign integ_term = integ_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_reg != '0)
        else $error("tick divider reached zero");

    a_delay_count: assert property (@(posedge aclk) disable iff (!aresetn)
        delay_cnt_reg < mvpi_pkg::DELAY_END && (delay_act_reg || delay_cnt_reg == '0))
        else $error("delay count out of step with delay flag");

    a_update_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_valid_reg && upd |=> div_reg == mvpi_pkg::DIV_TOP)
        else $error("divider not restarted after loop update");
`endif

endmodule

`default_nettype wire

>>> sv/mvpi_accum.sv
`default_nettype none

module mvpi_accum #(
    parameter int SPEED_WIDTH   = mvpi_pkg::SPEED_WIDTH_DEF,
    parameter int ACC_FRAC_BITS = mvpi_pkg::ACC_FRAC_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     adv,
    input  wire mvpi_pkg::tick_ctrl_t                     ctrl_in,
    input  wire logic signed [SPEED_WIDTH+18:0]           prop_term,
    input  wire logic signed [SPEED_WIDTH+17:0]           integ_term,
    output mvpi_pkg::tick_ctrl_t                          ctrl_out,
    output logic signed [mvpi_pkg::ACC_WIDTH-1:0]         acc
);

    localparam int SUM_W = SPEED_WIDTH + 20;
    localparam int RS_W  = SUM_W + mvpi_pkg::GAIN_FRAC_BITS;
    localparam int UP_SH = (ACC_FRAC_BITS >= mvpi_pkg::GAIN_FRAC_BITS) ?
                           ACC_FRAC_BITS - mvpi_pkg::GAIN_FRAC_BITS : 0;
    localparam int DN_SH = (ACC_FRAC_BITS < mvpi_pkg::GAIN_FRAC_BITS) ?
                           mvpi_pkg::GAIN_FRAC_BITS - ACC_FRAC_BITS : 0;
    localparam int AW    = ((RS_W > mvpi_pkg::ACC_WIDTH) ? RS_W : mvpi_pkg::ACC_WIDTH) + 1;

    localparam logic signed [AW-1:0] ACC_MAX =
        {{(AW - mvpi_pkg::ACC_WIDTH + 1){1'b0}}, {(mvpi_pkg::ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [SUM_W-1:0]              sum;
    logic signed [RS_W-1:0]               sum_ext, bias, scaled;
    logic signed [RS_W-1:0]               scaled_reg;
    mvpi_pkg::tick_ctrl_t                 ctrl2_reg, ctrl3_reg;
    logic signed [AW-1:0]                 acc_sum;
    logic signed [mvpi_pkg::ACC_WIDTH-1:0] acc_reg, acc_next;

    // product sum, rescaled to the accumulator's fraction with truncation toward zero
    always_comb begin
        sum     = SUM_W'(prop_term) + SUM_W'(integ_term);
        sum_ext = RS_W'(sum);
        bias    = sum[SUM_W-1] ? RS_W'((1 << DN_SH) - 1) : '0;
        scaled  = ((sum_ext + bias) >>> DN_SH) <<< UP_SH;
    end

    always_comb begin
        acc_sum = AW'(acc_reg) + AW'(scaled_reg);
        if (acc_sum > ACC_MAX) begin
            acc_next = ACC_MAX[mvpi_pkg::ACC_WIDTH-1:0];
        end else if (acc_sum < ACC_MIN) begin
            acc_next = ACC_MIN[mvpi_pkg::ACC_WIDTH-1:0];
        end else begin
            acc_next = acc_sum[mvpi_pkg::ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
            acc_reg   <= '0;
        end else if (adv) begin
            ctrl2_reg <= ctrl_in;
            ctrl3_reg <= ctrl2_reg;
            if (ctrl2_reg.valid && ctrl2_reg.updated) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            scaled_reg <= scaled;
        end
    end

    assign ctrl_out = ctrl3_reg;
    assign acc      = acc_reg;

`ifndef SYNTHESIS
    a_acc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(adv && ctrl2_reg.valid && ctrl2_reg.updated) |=> acc_reg == $past(acc_reg))
        else $error("accumulator moved without a loop update");
`endif

endmodule

`default_nettype wire

>>> sv/mvpi_drive.sv
`default_nettype none

module mvpi_drive #(
    parameter int ACC_FRAC_BITS = mvpi_pkg::ACC_FRAC_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      adv,
    input  wire mvpi_pkg::tick_ctrl_t                      ctrl_in,
    input  wire logic signed [mvpi_pkg::ACC_WIDTH-1:0]     acc,
    input  wire logic [mvpi_pkg::LIMIT_WIDTH-1:0]          drive_limit,
    output logic                                           out_valid,
    output logic [mvpi_pkg::LIMIT_WIDTH-1:0]               pwm_magnitude,
    output logic signed [mvpi_pkg::DRIVE_WIDTH-1:0]        motor_drive,
    output logic                                           loop_updated,
    output logic                                           delay_busy
);

    localparam int Q_W = mvpi_pkg::ACC_WIDTH - ACC_FRAC_BITS + 1;
    localparam logic [mvpi_pkg::ACC_WIDTH-1:0] FRAC_MASK =
        mvpi_pkg::ACC_WIDTH'(((mvpi_pkg::ACC_WIDTH + 1)'(1) << ACC_FRAC_BITS)
                             - (mvpi_pkg::ACC_WIDTH + 1)'(1));

    logic signed [Q_W-1:0]                   q, pre, lim_pos, lim_neg, clamped;
    logic                                    round_up;
    logic signed [mvpi_pkg::DRIVE_WIDTH-1:0] drive_reg, drive_next, mag;

    logic                                    out_valid_reg;
    logic [mvpi_pkg::LIMIT_WIDTH-1:0]        pwm_reg;
    logic                                    updated_reg, busy_reg;

    always_comb begin
        // shift rounds toward minus infinity, so bump negatives with a fraction left
        round_up = acc[mvpi_pkg::ACC_WIDTH-1] && ((acc & FRAC_MASK) != '0);
        q        = Q_W'(acc >>> ACC_FRAC_BITS) + Q_W'(round_up);
        pre      = ctrl_in.updated ? q : Q_W'(drive_reg);
        lim_pos  = Q_W'($signed({1'b0, drive_limit}));
        lim_neg  = -lim_pos;
        if (pre < lim_neg) begin
            clamped = lim_neg;
        end else if (pre > lim_pos) begin
            clamped = lim_pos;
        end else begin
            clamped = pre;
        end
        drive_next = clamped[mvpi_pkg::DRIVE_WIDTH-1:0];
        mag        = drive_next[mvpi_pkg::DRIVE_WIDTH-1] ? -drive_next : drive_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
        end else if (adv) begin
            out_valid_reg <= ctrl_in.valid;
            if (ctrl_in.valid) begin
                drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && ctrl_in.valid) begin
            pwm_reg     <= mag[mvpi_pkg::LIMIT_WIDTH-1:0];
            updated_reg <= ctrl_in.updated;
            busy_reg    <= ctrl_in.busy;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_magnitude = pwm_reg;
    assign motor_drive   = drive_reg;
    assign loop_updated  = updated_reg;
    assign delay_busy    = busy_reg;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int S_TDATA_W   = ((2*mvpi_pkg::SPEED_WIDTH_DEF+8)/8)*8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 8;
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_TICKS = 95;
    localparam int SAT_TICKS   = 900;
    localparam int SAT_TARGET  = 40;
    localparam int REPORT_MAX  = 10;

    localparam logic [mvpi_pkg::CFG_INDEX_WIDTH-1:0] REG_NONE = 2'd3;

    localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SPEED_MIN = 16'sh8000;
    localparam longint ACC_MAX = (longint'(1) <<< (mvpi_pkg::ACC_WIDTH-1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    typedef struct packed {
        logic               req;
        logic signed [15:0] tgt;
        logic signed [15:0] enc;
    } tick_t;

    typedef struct packed {
        logic               busy;
        logic               upd;
        logic signed [15:0] drive;
        logic [14:0]        pwm;
    } drive_out_t;

    typedef enum {ROW_TICK, ROW_CFG} row_kind_t;
    typedef enum {MODE_TRACK, MODE_WILD, MODE_SAT, MODE_TIGHT} phase_mode_t;

    typedef struct {
        row_kind_t                            kind;
        logic [mvpi_pkg::CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [mvpi_pkg::CFG_DATA_WIDTH-1:0]  reg_val;
        tick_t                                tick;
        bit                                   typed;
        drive_out_t                           want;
    } directed_row_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_tvalid;
    logic                                 s_tready;
    // encoder_speed[15:0], target_speed[31:16], delay_request[32], zero pad
    logic [S_TDATA_W-1:0]                 s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    // pwm_magnitude[14:0], motor_drive[30:15], loop_updated[31], delay_busy[32], zero pad
    logic [mvpi_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;
    logic                                 cfg_we;
    logic [mvpi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [mvpi_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    // controller copy kept in step with the block
    logic [mvpi_pkg::GAIN_WIDTH-1:0]  kp_reg  = '0;
    logic [mvpi_pkg::GAIN_WIDTH-1:0]  ki_reg  = '0;
    logic [mvpi_pkg::LIMIT_WIDTH-1:0] lim_reg = mvpi_pkg::LIMIT_RESET;
    longint                           acc     = 0;
    longint                           prev_err = 0;
    longint                           drv     = 0;
    logic [mvpi_pkg::DIV_WIDTH-1:0]   div_cnt = mvpi_pkg::DIV_RESET;
    logic [mvpi_pkg::DELAY_WIDTH-1:0] dly_cnt = '0;
    logic                             dly_on  = 1'b0;

    drive_out_t    pending_drive[$];
    directed_row_t directed_rows[$];

    int  mismatches    = 0;
    int  results_seen  = 0;
    int  updates_seen  = 0;
    int  ticks_sent    = 0;
    int  sat_hits      = 0;
    int  settings_used = 0;
    int  cycle_count   = 0;
    int  holds_asked   = 0;
    int  holds_done    = 0;
    int  hold_left     = 0;
    bit  steady        = 1'b0;

    motor_velocity_incremental_pi dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_drive.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // one control tick: delay flag, divider and PI update, then the clamp
    function automatic drive_out_t step_controller(input tick_t t);
        longint     err;
        longint     sum;
        longint     lim;
        longint     mag;
        drive_out_t r;
        lim   = longint'(lim_reg);
        r.upd = 1'b0;
        if (t.req)
            dly_on = 1'b1;
        if (dly_on) begin
            dly_cnt = dly_cnt + 3'd1;
            if (dly_cnt == mvpi_pkg::DELAY_END) begin
                dly_cnt = '0;
                dly_on  = 1'b0;
            end
        end
        if (div_cnt > mvpi_pkg::DIV_TOP) begin
            div_cnt = mvpi_pkg::DIV_RESET;
            err = longint'(t.enc) - longint'(t.tgt);
            sum = longint'(kp_reg) * (err - prev_err) + longint'(ki_reg) * err;
            if (mvpi_pkg::ACC_FRAC_DEF >= mvpi_pkg::GAIN_FRAC_BITS)
                sum = sum * (longint'(1) <<< (mvpi_pkg::ACC_FRAC_DEF - mvpi_pkg::GAIN_FRAC_BITS));
            else
                sum = sum / (longint'(1) <<< (mvpi_pkg::GAIN_FRAC_BITS - mvpi_pkg::ACC_FRAC_DEF));
            sum = acc + sum;
            if (sum > ACC_MAX) begin
                sum = ACC_MAX;
                sat_hits++;
            end
            if (sum < ACC_MIN) begin
                sum = ACC_MIN;
                sat_hits++;
            end
            acc      = sum;
            prev_err = err;
            // integer division truncates toward zero
            drv   = sum / (longint'(1) <<< mvpi_pkg::ACC_FRAC_DEF);
            r.upd = 1'b1;
        end
        div_cnt = div_cnt + 2'd1;
        if (drv < -lim)
            drv = -lim;
        if (drv > lim)
            drv = lim;
        mag     = (drv < 0) ? -drv : drv;
        r.pwm   = mag[14:0];
        r.drive = drv[15:0];
        r.busy  = dly_on;
        return r;
    endfunction

    function automatic void add_tick(input logic signed [15:0] enc,
                                     input logic signed [15:0] tgt, input logic req);
        directed_row_t row;
        row.kind    = ROW_TICK;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.tick    = '{req: req, tgt: tgt, enc: enc};
        row.typed   = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endfunction

    // rows whose drive is known to be zero: gains at zero or limit at zero
    function automatic void add_zero_drive(input logic signed [15:0] enc,
                                           input logic signed [15:0] tgt, input logic req,
                                           input logic upd, input logic busy);
        directed_row_t row;
        row.kind    = ROW_TICK;
        row.reg_idx = '0;
        row.reg_val = '0;
        row.tick    = '{req: req, tgt: tgt, enc: enc};
        row.typed   = 1'b1;
        row.want    = '{busy: busy, upd: upd, drive: '0, pwm: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [mvpi_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                    input logic [mvpi_pkg::CFG_DATA_WIDTH-1:0] val);
        directed_row_t row;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.tick    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic tick_t make_tick(input phase_mode_t mode, input bit sat_up);
        tick_t            t;
        logic [15:0]      base;
        int               off;
        t.req = ($urandom_range(0, 11) == 0);
        t.enc = 16'($urandom);
        t.tgt = 16'($urandom);
        case (mode)
            MODE_TRACK: begin
                base  = 16'($urandom);
                off   = int'($urandom_range(0, 64)) - 32;
                t.tgt = base;
                t.enc = 16'(int'(base) + off);
            end
            MODE_SAT: begin
                if ($urandom_range(0, 7) != 0) begin
                    t.enc = sat_up ? SPEED_MAX : SPEED_MIN;
                    t.tgt = sat_up ? SPEED_MIN : SPEED_MAX;
                end
            end
            MODE_TIGHT: begin
                // frequent requests land on every phase of the delay count
                t.req = 1'($urandom_range(0, 1));
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic write_reg(input logic [mvpi_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [mvpi_pkg::CFG_DATA_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            mvpi_pkg::REG_PROP_GAIN:   kp_reg  = val[mvpi_pkg::GAIN_WIDTH-1:0];
            mvpi_pkg::REG_INTEG_GAIN:  ki_reg  = val[mvpi_pkg::GAIN_WIDTH-1:0];
            mvpi_pkg::REG_DRIVE_LIMIT: lim_reg = val[mvpi_pkg::LIMIT_WIDTH-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_drive.size() != 0);
    endtask

    task automatic send_tick(input tick_t t, input bit typed, input drive_out_t want);
        drive_out_t predicted;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-33){1'b0}}, t.req, t.tgt, t.enc};
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = step_controller(t);
        pending_drive.push_back(typed ? want : predicted);
        ticks_sent++;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        drive_out_t got;
        drive_out_t exp_out;
        if (aresetn && m_tvalid && m_tready) begin
            got.pwm   = m_tdata[14:0];
            got.drive = m_tdata[30:15];
            got.upd   = m_tdata[31];
            got.busy  = m_tdata[32];
            results_seen++;
            updates_seen += int'(got.upd);
            if (pending_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("tb_top: unexpected result pwm %0d drive %0d upd %0d busy %0d",
                             got.pwm, got.drive, got.upd, got.busy);
            end else begin
                exp_out = pending_drive.pop_front();
                if (got !== exp_out) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("tb_top: result %0d expected pwm %0d drive %0d upd %0d busy %0d",
                                 results_seen, exp_out.pwm, exp_out.drive, exp_out.upd,
                                 exp_out.busy);
                        $display("tb_top: result %0d actual   pwm %0d drive %0d upd %0d busy %0d",
                                 results_seen, got.pwm, got.drive, got.upd, got.busy);
                    end
                end
            end
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != holds_asked) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int                                  p;
        int                                  i;
        int                                  sat_mark;
        bit                                  in_cfg;
        bit                                  sat_up;
        phase_mode_t                         mode;
        logic [mvpi_pkg::CFG_DATA_WIDTH-1:0] kp_val;
        logic [mvpi_pkg::CFG_DATA_WIDTH-1:0] ki_val;
        logic [mvpi_pkg::CFG_DATA_WIDTH-1:0] lim_val;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // reset values: gains zero so the drive stays zero whatever the speeds
        add_zero_drive(SPEED_MAX, SPEED_MIN, 1'b1, 1'b0, 1'b1);
        add_zero_drive(SPEED_MIN, SPEED_MAX, 1'b0, 1'b0, 1'b1);
        add_zero_drive(16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1);
        // request while the flag is set does not restart the count
        add_zero_drive(-16'sd1, 16'sd1, 1'b1, 1'b0, 1'b1);
        // request on the clearing tick is absorbed
        add_zero_drive(16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0);
        add_zero_drive(16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
        add_cfg(mvpi_pkg::REG_PROP_GAIN, 16'h0100);
        add_cfg(mvpi_pkg::REG_INTEG_GAIN, 16'h0100);
        add_tick(16'sd100, 16'sd0, 1'b0);
        add_tick(16'sd100, 16'sd0, 1'b0);
        add_tick(16'sd50, 16'sd0, 1'b1);
        add_tick(-16'sd200, 16'sd0, 1'b0);
        add_tick(16'sd0, 16'sd7, 1'b0);
        add_tick(16'sd0, 16'sd0, 1'b0);
        add_cfg(mvpi_pkg::REG_PROP_GAIN, 16'hFFFF);
        add_cfg(mvpi_pkg::REG_INTEG_GAIN, 16'hFFFF);
        add_cfg(mvpi_pkg::REG_DRIVE_LIMIT, 16'h7FFF);
        for (i = 0; i < 4; i++)
            add_tick(SPEED_MAX, SPEED_MIN, 1'b0);
        for (i = 0; i < 4; i++)
            add_tick(SPEED_MIN, SPEED_MAX, 1'b0);
        // top bit lies above the limit field, so this sets the limit to zero
        add_cfg(mvpi_pkg::REG_DRIVE_LIMIT, 16'h8000);
        add_cfg(REG_NONE, 16'h1234);
        add_zero_drive(SPEED_MAX, SPEED_MIN, 1'b0, 1'b1, 1'b0);
        add_zero_drive(SPEED_MIN, SPEED_MAX, 1'b0, 1'b0, 1'b0);
        add_zero_drive(SPEED_MAX, SPEED_MIN, 1'b0, 1'b1, 1'b0);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        settings_used = 1;
        in_cfg = 1'b0;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                if (!in_cfg) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                    in_cfg = 1'b1;
                    settings_used++;
                end
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                if (in_cfg) begin
                    cfg_we <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_tick(directed_rows[k].tick, directed_rows[k].typed,
                          directed_rows[k].want);
            end
        end

        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p % 3)
                0:       mode = MODE_TRACK;
                1:       mode = MODE_WILD;
                default: mode = MODE_TIGHT;
            endcase
            if (p == 2 || p == 6)
                mode = MODE_SAT;
            sat_up = (p == 6);
            s_tvalid <= 1'b0;
            wait_drained();
            steady = (p == 4);
            case (mode)
                MODE_TRACK: begin
                    kp_val  = 16'($urandom_range(0, 16'h0300));
                    ki_val  = 16'($urandom_range(0, 16'h0080));
                    lim_val = 16'($urandom_range(1, 32767));
                end
                MODE_SAT: begin
                    kp_val  = 16'hFFFF;
                    ki_val  = 16'hFFFF;
                    lim_val = 16'h7FFF;
                end
                MODE_TIGHT: begin
                    kp_val  = 16'($urandom);
                    ki_val  = 16'($urandom_range(0, 16'h0400));
                    lim_val = 16'($urandom_range(0, 60));
                end
                default: begin
                    kp_val  = 16'($urandom);
                    ki_val  = 16'($urandom);
                    lim_val = 16'($urandom);
                end
            endcase
            write_reg(mvpi_pkg::REG_PROP_GAIN, kp_val);
            write_reg(mvpi_pkg::REG_INTEG_GAIN, ki_val);
            write_reg(mvpi_pkg::REG_DRIVE_LIMIT, lim_val);
            if (p == 5)
                write_reg(REG_NONE, 16'($urandom));
            cfg_we <= 1'b0;
            settings_used++;
            // receiver holds off while the sender keeps offering ticks
            if (p == 5)
                holds_asked++;
            sat_mark = sat_hits;
            i = 0;
            while (mode == MODE_SAT ? (sat_hits - sat_mark < SAT_TARGET && i < SAT_TICKS)
                                    : (i < PHASE_TICKS)) begin
                if (p == 7 && i == PHASE_TICKS/2) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                send_tick(make_tick(mode, sat_up), 1'b0, '0);
                i++;
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(negedge aclk);

        $display("tb_top: %0d control ticks over %0d gain and limit settings, %0d results",
                 ticks_sent, settings_used, results_seen);
        $display("tb_top: %0d PI updates seen, %0d saturating accumulator updates, %0d mismatches",
                 updates_seen, sat_hits, mismatches);
        if (mismatches == 0 && pending_drive.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
sv/mvpi_pkg.sv
sv/mvpi_front.sv
sv/mvpi_accum.sv
sv/mvpi_drive.sv
sv/motor_velocity_incremental_pi.sv
test/tb_top.sv
